### src/fsk_tape_byte_modulator_macros.svh
// Assertion helpers shared by the modulator RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef FSK_TAPE_BYTE_MODULATOR_MACROS_SVH
`define FSK_TAPE_BYTE_MODULATOR_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define FSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define FSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fsk_pkg.sv
`timescale 1ns / 1ps
package fsk_pkg;

    // Sine table geometry
    localparam int SINE_ENTRIES = 1024;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int QN           = SINE_ENTRIES / 4;
    localparam int QN_W         = IDX_W - 2;
    localparam int MAG_W        = 15;

    // Frame layout
    localparam int FRAME_BITS   = 10;
    localparam int BITS_W       = $clog2(FRAME_BITS + 1);
    localparam int CELL_W       = 6;

    localparam int AMP_W        = 15;
    localparam int SAMPLE_W     = 16;

    // Decoupling queue
    localparam int Q_DEPTH      = 4;
    localparam int QPTR_W       = $clog2(Q_DEPTH);
    localparam int QCNT_W       = $clog2(Q_DEPTH + 1);

    // Configuration registers
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    typedef enum logic [1:0] {
        REG_MARK_STEP  = 2'd0,
        REG_SPACE_STEP = 2'd1,
        REG_SPB        = 2'd2
    } t_reg_idx;

    localparam logic [31:0]       MARK_STEP_RST  = 32'd126609011;
    localparam logic [31:0]       SPACE_STEP_RST = 32'd204522249;
    localparam logic [CELL_W-1:0] SPB_RST        = 6'd36;

    localparam logic [0:0] REQ_TICK = 1'b0;
    localparam logic [0:0] REQ_LOAD = 1'b1;

    typedef struct packed {
        logic [31:0]       mark_step;
        logic [31:0]       space_step;
        logic [CELL_W-1:0] samples_per_bit;
    } t_cfg;

    // One tick on its way from the front end to the sample pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [AMP_W-1:0] amp;
        logic             busy;
        logic             overrun;
    } t_tick;

    typedef logic [QN-1:0][MAG_W-1:0] t_qtab;

    // Quarter-wave magnitudes; entry k is the polynomial sine at z = k of QN
    function automatic t_qtab build_qtab();
        t_qtab         tab;
        longint        z;
        longint        z2;
        longint        t1;
        longint        t3;
        longint        y;
        int            k;
        tab = '0;
        for (k = 0; k < QN; k++) begin
            z  = longint'(k) << (16 - IDX_W);
            z2 = (z * z) >>> 14;
            t1 = (z2 * 2320) >>> 14;
            t3 = (z2 * (21024 - t1)) >>> 14;
            y  = (z * (51472 - t3)) >>> 14;
            if (y > 32767) begin
                y = 32767;
            end
            tab[k] = MAG_W'(y);
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();
    localparam logic [MAG_W-1:0] QUARTER_PEAK = 15'd32767;

endpackage

### src/fsk_chan_if.sv
`timescale 1ns / 1ps
interface fsk_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [7:0]                    byte_value;
    logic [fsk_pkg::AMP_W-1:0]     amplitude;

    modport source (output valid, output req_type, output byte_value, output amplitude,
                    input ready);
    modport sink (input valid, input req_type, input byte_value, input amplitude,
                  output ready);
endinterface

interface fsk_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fsk_pkg::SAMPLE_W-1:0] sample;
    logic                                busy_res;
    logic                                overrun;

    modport source (output valid, output sample, output busy_res, output overrun,
                    input ready);
    modport sink (input valid, input sample, input busy_res, input overrun,
                  output ready);
endinterface

### src/fsk_front.sv
`timescale 1ns / 1ps
`include "fsk_tape_byte_modulator_macros.svh"
module fsk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fsk_in_if.sink            i_in,
    input  fsk_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output fsk_pkg::t_tick    o_tick
);

    logic [31:0]                      r_phase;
    logic [fsk_pkg::FRAME_BITS-1:0]   r_frame;
    logic [fsk_pkg::BITS_W-1:0]       r_bits_left;
    logic [fsk_pkg::CELL_W-1:0]       r_cell;
    logic                             r_drop;

    logic [31:0]                      n_phase;
    logic [fsk_pkg::FRAME_BITS-1:0]   n_frame;
    logic [fsk_pkg::BITS_W-1:0]       n_bits_left;
    logic [fsk_pkg::CELL_W-1:0]       n_cell;
    logic                             n_drop;

    logic                             accept;
    logic                             busy;
    logic [31:0]                      step;
    logic [fsk_pkg::CELL_W-1:0]       cell_inc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign busy       = r_bits_left != '0;
    assign step       = (busy && !r_frame[0]) ? i_cfg.space_step : i_cfg.mark_step;
    assign cell_inc   = r_cell + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_frame     = r_frame;
        n_bits_left = r_bits_left;
        n_cell      = r_cell;
        n_drop      = r_drop;
        if (accept) begin
            case (i_in.req_type)
                fsk_pkg::REQ_LOAD: begin
                    if (busy) begin
                        n_drop = 1'b1;
                    end else begin
                        n_frame     = {1'b1, i_in.byte_value, 1'b0};
                        n_bits_left = fsk_pkg::BITS_W'(fsk_pkg::FRAME_BITS);
                        n_cell      = '0;
                    end
                end
                default: begin
                    n_phase = r_phase + step;
                    n_drop  = 1'b0;
                    if (busy) begin
                        if (cell_inc == i_cfg.samples_per_bit) begin
                            n_cell      = '0;
                            n_frame     = r_frame >> 1;
                            n_bits_left = r_bits_left - 1'b1;
                        end else begin
                            n_cell = cell_inc;
                        end
                    end
                end
            endcase
        end
    end

    assign o_push         = accept && (i_in.req_type == fsk_pkg::REQ_TICK);
    assign o_tick.idx     = n_phase[31 -: fsk_pkg::IDX_W];
    assign o_tick.amp     = i_in.amplitude;
    assign o_tick.busy    = n_bits_left != '0;
    assign o_tick.overrun = r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_frame     <= '0;
            r_bits_left <= '0;
            r_cell      <= '0;
            r_drop      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_frame     <= n_frame;
            r_bits_left <= n_bits_left;
            r_cell      <= n_cell;
            r_drop      <= n_drop;
        end
    end

    `FSK_ASSERT_NEXT(a_drop_on_busy_load,
        accept && i_in.req_type == fsk_pkg::REQ_LOAD && busy, r_drop,
        "load while busy did not raise the drop flag")
    `FSK_ASSERT_NOW(a_bits_bound,
        1'b1, r_bits_left <= fsk_pkg::BITS_W'(fsk_pkg::FRAME_BITS),
        "bit counter beyond frame length")

endmodule

### src/fsk_queue.sv
`timescale 1ns / 1ps
`include "fsk_tape_byte_modulator_macros.svh"
module fsk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fsk_pkg::t_tick    i_tick,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output fsk_pkg::t_tick    o_head
);

    fsk_pkg::t_tick                r_mem [fsk_pkg::Q_DEPTH];
    logic [fsk_pkg::QPTR_W-1:0]    r_wr;
    logic [fsk_pkg::QPTR_W-1:0]    r_rd;
    logic [fsk_pkg::QCNT_W-1:0]    r_count;
    logic                          pop_ok;

    assign o_full  = r_count == fsk_pkg::QCNT_W'(fsk_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `FSK_ASSERT_NOW(a_no_push_full, i_push, !o_full, "push into a full queue")
    `FSK_ASSERT_NOW(a_count_bound, 1'b1,
        r_count <= fsk_pkg::QCNT_W'(fsk_pkg::Q_DEPTH), "queue count overflow")

endmodule

### src/fsk_back.sv
`timescale 1ns / 1ps
`include "fsk_tape_byte_modulator_macros.svh"
module fsk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  fsk_pkg::t_tick    i_head,
    output logic              o_pop,
    fsk_out_if.source         o_out
);

    // Stage 1: table magnitude
    logic                            r_s1_valid;
    logic [fsk_pkg::MAG_W-1:0]       r_s1_mag;
    logic                            r_s1_neg;
    logic [fsk_pkg::AMP_W-1:0]       r_s1_amp;
    logic                            r_s1_busy;
    logic                            r_s1_ovr;

    // Stage 2: output beat
    logic                            r_out_valid;
    logic signed [fsk_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                            r_out_busy;
    logic                            r_out_ovr;

    logic                            advance;
    logic [1:0]                      quad;
    logic [fsk_pkg::QN_W-1:0]        k;
    logic [fsk_pkg::MAG_W-1:0]       mag;
    logic [2*fsk_pkg::MAG_W-1:0]     prod;
    logic [fsk_pkg::SAMPLE_W-1:0]    pos;

    assign advance = !r_out_valid || o_out.ready;
    assign o_pop   = advance && i_q_valid;

    assign quad = i_head.idx[fsk_pkg::IDX_W-1 -: 2];
    assign k    = i_head.idx[fsk_pkg::QN_W-1:0];

    // Odd quadrants mirror the quarter wave; their first entry is the peak
    always_comb begin
        if (!quad[0]) begin
            mag = fsk_pkg::QTAB[k];
        end else if (k == '0) begin
            mag = fsk_pkg::QUARTER_PEAK;
        end else begin
            mag = fsk_pkg::QTAB[fsk_pkg::QN_W'(-k)];
        end
    end

    assign prod = r_s1_mag * r_s1_amp;
    assign pos  = {1'b0, prod[2*fsk_pkg::MAG_W-1 -: fsk_pkg::MAG_W]};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_mag  <= mag;
            r_s1_neg  <= quad[1];
            r_s1_amp  <= i_head.amp;
            r_s1_busy <= i_head.busy;
            r_s1_ovr  <= i_head.overrun;
        end
        if (advance && r_s1_valid) begin
            r_out_sample <= r_s1_neg ? -$signed(pos) : $signed(pos);
            r_out_busy   <= r_s1_busy;
            r_out_ovr    <= r_s1_ovr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_q_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.sample   = r_out_sample;
    assign o_out.busy_res = r_out_busy;
    assign o_out.overrun  = r_out_ovr;

    `FSK_ASSERT_NEXT(a_s1_hold, r_s1_valid && !advance,
        r_s1_valid && $stable(r_s1_mag) && $stable(r_s1_amp),
        "stage 1 lost its tick during a stall")

endmodule

### src/fsk_tape_byte_modulator.sv
`timescale 1ns / 1ps
// Phase-continuous FSK tape modulator. Send a load beat (req_type 1) to frame a
// byte as start bit, eight data bits LSB first and stop bit; send a tick beat
// (req_type 0) to get one signed sample of the current tone scaled by the
// beat's amplitude. Mark is sent for 1 bits and while idle, space for 0 bits;
// each bit lasts samples_per_bit ticks (0 means 64). A load while a frame is
// in progress is dropped and reported as overrun on the next tick's result.
// The block takes one beat per clock while the queue is not full: the front end
// updates the phase accumulator and frame state as it accepts each beat, and a
// tick's result is registered behind a four-entry queue and a two-stage
// sample pipeline (quarter-wave table lookup, then the amplitude multiply).
// Loads produce no result. Configuration sits on an APB port:
// mark_step at 0x0, space_step at 0x4, samples_per_bit at 0x8; write it only
// while no tick is in flight.
module fsk_tape_byte_modulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fsk_in_if.sink                         i_in,
    fsk_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fsk_pkg::PADDR_W-1:0]    paddr,
    input  logic [fsk_pkg::PDATA_W-1:0]    pwdata,
    output logic [fsk_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [31:0]                 r_mark_step;
    logic [31:0]                 r_space_step;
    logic [fsk_pkg::CELL_W-1:0]  r_spb;

    fsk_pkg::t_cfg               cfg;
    fsk_pkg::t_tick              fr_tick;
    fsk_pkg::t_tick              q_head;
    logic                        fr_push;
    logic                        q_full;
    logic                        q_valid;
    logic                        bk_pop;
    logic                        cfg_wr;
    fsk_pkg::t_reg_idx           reg_idx;

    // APB: zero wait states, write on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = fsk_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_step  <= fsk_pkg::MARK_STEP_RST;
            r_space_step <= fsk_pkg::SPACE_STEP_RST;
            r_spb        <= fsk_pkg::SPB_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                fsk_pkg::REG_MARK_STEP:  r_mark_step  <= pwdata;
                fsk_pkg::REG_SPACE_STEP: r_space_step <= pwdata;
                fsk_pkg::REG_SPB:        r_spb        <= pwdata[fsk_pkg::CELL_W-1:0];
                default:                 ; // unmapped offset: drop the write
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fsk_pkg::REG_MARK_STEP:  prdata = r_mark_step;
            fsk_pkg::REG_SPACE_STEP: prdata = r_space_step;
            fsk_pkg::REG_SPB:        prdata = {{(fsk_pkg::PDATA_W-fsk_pkg::CELL_W){1'b0}}, r_spb};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.mark_step       = r_mark_step;
    assign cfg.space_step      = r_space_step;
    assign cfg.samples_per_bit = r_spb;

    // Front end: accept beats, run the frame and phase state, queue ticks
    fsk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (fr_push),
        .o_tick   (fr_tick)
    );

    // Queue lets the front keep taking beats while the output stalls
    fsk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_tick  (fr_tick),
        .i_pop   (bk_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back end: sine lookup, amplitude scaling, output register
    fsk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (bk_pop),
        .o_out     (o_out)
    );

endmodule
